[rtl/cpth_pkg.sv]
// ----------------------------------------------------------------------------
// cpth_pkg
// Shared types and constants of the console palette to host color converter.
// ----------------------------------------------------------------------------
package cpth_pkg;

    localparam int ENTRY_COUNT_DEF = 32;
    localparam int RAM_WIDTH       = 8;
    localparam int RAM_DEPTH       = 64;
    localparam int RAM_AW          = 6;
    localparam int QUEUE_DEPTH     = 2;

    typedef enum logic [1:0] {
        MODE_WRITE  = 2'd0,
        MODE_CLEAR  = 2'd1,
        MODE_RELOAD = 2'd2,
        MODE_UNUSED = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        CFG_MACHINE_KIND = 2'd0,
        CFG_GUI_FORMAT   = 2'd1,
        CFG_GAME_FORMAT  = 2'd2,
        CFG_NONE         = 2'd3
    } t_cfg_index;

    typedef enum logic [2:0] {
        FMT_RGB565 = 3'd0,
        FMT_RGB555 = 3'd1,
        FMT_BGR565 = 3'd2,
        FMT_BGR555 = 3'd3,
        FMT_ARGB   = 3'd4,
        FMT_RGBA   = 3'd5,
        FMT_ABGR   = 3'd6,
        FMT_NONE   = 3'd7
    } t_format;

    localparam logic MACHINE_SMS = 1'b0;
    localparam logic MACHINE_GG  = 1'b1;

    typedef struct packed {
        logic [1:0] mode;
        logic [5:0] ram_address;
        logic [7:0] ram_data;
    } t_in_item;

    typedef struct packed {
        logic [4:0]  entry_index;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [31:0] gui_color;
        logic [15:0] game_color;
        logic        last_entry;
    } t_out_item;

    typedef struct packed {
        logic [1:0] index;
        logic [2:0] value;
    } t_cfg_wr;

    typedef struct packed {
        logic       machine_kind;
        logic [2:0] gui_format;
        logic [2:0] game_format;
    } t_cfg;

    typedef struct packed {
        logic              is_reload;
        logic [RAM_AW-1:0] addr;
        logic [7:0]        data;
    } t_cmd;

endpackage

[rtl/cpth_if.sv]
// ----------------------------------------------------------------------------
// cpth_if
// Valid/ready channels of the converter: input items, results, config writes.
// ----------------------------------------------------------------------------
interface cpth_in_if;
    logic               valid;
    logic               ready;
    cpth_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cpth_out_if;
    logic                valid;
    logic                ready;
    cpth_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cpth_cfg_if;
    logic              valid;
    logic              ready;
    cpth_pkg::t_cfg_wr data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/cpth_ram.sv]
// ----------------------------------------------------------------------------
// cpth_ram
// Generic RAM, one write port and two registered read ports with enable.
// ----------------------------------------------------------------------------
module cpth_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

[rtl/cpth_front.sv]
// ----------------------------------------------------------------------------
// cpth_front
// Accepts input items and forwards writes and reloads as commands.
// ----------------------------------------------------------------------------
module cpth_front (
    cpth_in_if.sink             i_in,
    input  logic                i_full,
    output logic                o_push,
    output cpth_pkg::t_cmd      o_cmd
);
    import cpth_pkg::*;

    logic w_is_write;
    logic w_is_reload;

    assign i_in.ready  = !i_full;
    assign w_is_write  = (i_in.data.mode == MODE_WRITE);
    assign w_is_reload = (i_in.data.mode == MODE_RELOAD);

    // clear and unused modes leave nothing visible, so they are dropped here
    assign o_push          = i_in.valid && !i_full && (w_is_write || w_is_reload);
    assign o_cmd.is_reload = w_is_reload;
    assign o_cmd.addr      = i_in.data.ram_address;
    assign o_cmd.data      = i_in.data.ram_data;

endmodule

[rtl/cpth_queue.sv]
// ----------------------------------------------------------------------------
// cpth_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module cpth_queue #(
    parameter int DEPTH = cpth_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cpth_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output cpth_pkg::t_cmd o_cmd
);
    import cpth_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_slot [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_wr_ptr;
    logic [PW-1:0] n_rd_ptr;
    logic [CW-1:0] n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

[rtl/cpth_back.sv]
// ----------------------------------------------------------------------------
// cpth_back
// Executes commands: palette byte writes and reload walks with color packing.
// ----------------------------------------------------------------------------
module cpth_back #(
    parameter int ENTRY_COUNT = cpth_pkg::ENTRY_COUNT_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cpth_pkg::t_cfg i_cfg,
    input  logic           i_empty,
    input  cpth_pkg::t_cmd i_cmd,
    output logic           o_pop,
    cpth_out_if.source     o_out
);
    import cpth_pkg::*;

    localparam int CW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

    logic                 r_busy;
    logic [CW-1:0]        r_idx;
    logic                 r_pend;
    logic [4:0]           r_pend_idx;
    logic                 r_pend_last;
    logic [RAM_DEPTH-1:0] r_valid;
    logic                 r_va;
    logic                 r_vb;
    logic                 r_out_valid;
    t_out_item            r_out;

    logic [6:0]           w_idx_ext;
    logic [RAM_AW-1:0]    w_addr_a;
    logic [RAM_AW-1:0]    w_addr_b;
    logic [7:0]           w_rdata_a;
    logic [7:0]           w_rdata_b;
    logic [7:0]           w_byte_a;
    logic [7:0]           w_byte_b;
    logic                 w_we;
    logic                 w_issue;
    logic                 w_load;
    logic                 w_last;
    logic [7:0]           w_r;
    logic [7:0]           w_g;
    logic [7:0]           w_b;
    logic [31:0]          w_game_full;
    t_out_item            w_out;

    function automatic logic [31:0] pack_color(
        input logic [2:0] fmt,
        input logic [7:0] r,
        input logic [7:0] g,
        input logic [7:0] b
    );
        logic [31:0] res;
        case (fmt)
            FMT_RGB565: res = {16'h0000, r[7:3], g[7:2], b[7:3]};
            FMT_RGB555: res = {17'h00000, r[7:3], g[7:3], b[7:3]};
            FMT_BGR565: res = {16'h0000, b[7:3], g[7:2], r[7:3]};
            FMT_BGR555: res = {17'h00000, b[7:3], g[7:3], r[7:3]};
            FMT_ARGB:   res = {8'hFF, r, g, b};
            FMT_RGBA:   res = {r, g, b, 8'hFF};
            FMT_ABGR:   res = {8'hFF, b, g, r};
            default:    res = 32'h0000_0000;
        endcase
        return res;
    endfunction

    assign w_idx_ext = 7'(r_idx);
    assign w_addr_a  = (i_cfg.machine_kind == MACHINE_GG) ? {w_idx_ext[4:0], 1'b0}
                                                          : w_idx_ext[5:0];
    assign w_addr_b  = {w_idx_ext[4:0], 1'b1};
    assign w_last    = (r_idx == CW'(ENTRY_COUNT - 1));

    assign o_pop   = !r_busy && !i_empty;
    assign w_we    = o_pop && !i_cmd.is_reload;
    assign w_load  = r_pend && (!r_out_valid || o_out.ready);
    assign w_issue = r_busy && (!r_pend || w_load);

    cpth_ram #(
        .WIDTH (RAM_WIDTH),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (i_cmd.addr),
        .i_wdata   (i_cmd.data),
        .i_re      (w_issue),
        .i_raddr_a (w_addr_a),
        .i_raddr_b (w_addr_b),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );

    // never-written bytes read as zero
    assign w_byte_a = r_va ? w_rdata_a : 8'h00;
    assign w_byte_b = r_vb ? w_rdata_b : 8'h00;

    always_comb begin
        if (i_cfg.machine_kind == MACHINE_GG) begin
            w_r = {2{w_byte_a[3:0]}};
            w_g = {2{w_byte_a[7:4]}};
            w_b = {2{w_byte_b[3:0]}};
        end else begin
            w_r = {4{w_byte_a[1:0]}};
            w_g = {4{w_byte_a[3:2]}};
            w_b = {4{w_byte_a[5:4]}};
        end
    end

    assign w_game_full       = pack_color(i_cfg.game_format, w_r, w_g, w_b);
    assign w_out.entry_index = r_pend_idx;
    assign w_out.red         = w_r;
    assign w_out.green       = w_g;
    assign w_out.blue        = w_b;
    assign w_out.gui_color   = pack_color(i_cfg.gui_format, w_r, w_g, w_b);
    assign w_out.game_color  = w_game_full[15:0];
    assign w_out.last_entry  = r_pend_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop && i_cmd.is_reload) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (w_issue) begin
                if (w_last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (w_we) begin
                r_valid[i_cmd.addr] <= 1'b1;
            end
            if (w_issue) begin
                r_pend <= 1'b1;
            end else if (w_load) begin
                r_pend <= 1'b0;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_pend_idx  <= w_idx_ext[4:0];
            r_pend_last <= w_last;
            r_va        <= r_valid[w_addr_a];
            r_vb        <= r_valid[w_addr_b];
        end
        if (w_load) begin
            r_out <= w_out;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule

[rtl/console_palette_to_host_color.sv]
// ----------------------------------------------------------------------------
// console_palette_to_host_color
// Console palette RAM with conversion of every entry to host pixel formats.
//
//   port    dir  payload       role
//   i_in    in   t_in_item     write byte, clear, reload commands
//   o_out   out  t_out_item    one beat per entry on a reload
//   i_cfg   in   t_cfg_wr      machine kind and pixel formats
//
// a write is done in the back end as its command is popped; a reload gives
// one beat per cycle per entry (ENTRY_COUNT beats) while the sink keeps up,
// read through the RAM read register and held in an output register;
// a stalled sink stops the walk, and a full command queue stalls i_in
// synchronous reset clears the palette to zero; config writes always accepted
// ----------------------------------------------------------------------------
module console_palette_to_host_color #(
    parameter int ENTRY_COUNT = cpth_pkg::ENTRY_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cpth_in_if.sink     i_in,
    cpth_out_if.source  o_out,
    cpth_cfg_if.sink    i_cfg
);
    import cpth_pkg::*;

    t_cfg r_cfg;
    logic w_push;
    t_cmd w_push_cmd;
    logic w_full;
    logic w_pop;
    logic w_empty;
    t_cmd w_head_cmd;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.index)
                CFG_MACHINE_KIND: r_cfg.machine_kind <= i_cfg.data.value[0];
                CFG_GUI_FORMAT:   r_cfg.gui_format   <= i_cfg.data.value;
                CFG_GAME_FORMAT:  r_cfg.game_format  <= i_cfg.data.value;
                default: begin
                end
            endcase
        end
    end

    cpth_front u_front (
        .i_in   (i_in),
        .i_full (w_full),
        .o_push (w_push),
        .o_cmd  (w_push_cmd)
    );

    cpth_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_cmd   (w_head_cmd)
    );

    cpth_back #(
        .ENTRY_COUNT (ENTRY_COUNT)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_empty (w_empty),
        .i_cmd   (w_head_cmd),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule
